/* hdl/prr_pkg.sv */
package prr_pkg;

  localparam int PERM_LENGTH = 9;
  localparam int ELEM_W = 4;
  localparam int RANK_W = 19;
  localparam int NUM_LEVELS = PERM_LENGTH - 1;
  localparam int LATENCY = 2 * NUM_LEVELS + 2;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [RANK_W-1:0] rank_t;

  typedef enum logic {
    OP_RANK   = 1'b0,
    OP_UNRANK = 1'b1
  } op_t;

  typedef struct packed {
    logic                    valid;
    op_t                     op;
    elem_t [PERM_LENGTH-1:0] p;
    elem_t [PERM_LENGTH-1:0] r;
    rank_t                   acc;
    rank_t                   quo;
  } stage_t;

  // Reciprocals floor(2**RANK_W / n), indexed by n.
  localparam rank_t RECIP [2:PERM_LENGTH] = '{
    19'd262144, 19'd174762, 19'd131072, 19'd104857,
    19'd87381,  19'd74898,  19'd65536,  19'd58254
  };

  // Mixed-radix weight of the digit taken at level n: product of n+1 .. PERM_LENGTH.
  localparam rank_t WEIGHT [2:PERM_LENGTH] = '{
    19'd181440, 19'd60480, 19'd15120, 19'd3024,
    19'd504,    19'd72,    19'd9,     19'd1
  };

endpackage

/* hdl/prr_front.sv */
module prr_front (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      take,
  input  prr_pkg::op_t                              op,
  input  prr_pkg::elem_t [prr_pkg::PERM_LENGTH-1:0] elem_in,
  input  prr_pkg::rank_t                            rank_in,
  output prr_pkg::stage_t                           q
);

  prr_pkg::elem_t [prr_pkg::PERM_LENGTH-1:0] sat;
  prr_pkg::elem_t [prr_pkg::PERM_LENGTH-1:0] inv;
  prr_pkg::elem_t [prr_pkg::PERM_LENGTH-1:0] ident;
  prr_pkg::stage_t                           q_next;

  always_comb begin
    for (int i = 0; i < prr_pkg::PERM_LENGTH; i++) begin
      if (elem_in[i] >= prr_pkg::elem_t'(prr_pkg::PERM_LENGTH)) begin
        sat[i] = prr_pkg::elem_t'(prr_pkg::PERM_LENGTH - 1);
      end else begin
        sat[i] = elem_in[i];
      end
      ident[i] = prr_pkg::elem_t'(i);
    end
    // Later positions win when an element value repeats.
    inv = '0;
    for (int i = 0; i < prr_pkg::PERM_LENGTH; i++) begin
      inv[sat[i]] = prr_pkg::elem_t'(i);
    end
    q_next.valid = take;
    q_next.op    = op;
    q_next.p     = (op == prr_pkg::OP_UNRANK) ? ident : sat;
    q_next.r     = inv;
    q_next.acc   = (op == prr_pkg::OP_UNRANK) ? rank_in : '0;
    q_next.quo   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q <= q_next;
    end
  end

endmodule

/* hdl/prr_recip.sv */
module prr_recip (
  input  logic            clk,
  input  logic            rst,
  input  prr_pkg::elem_t  n,
  input  prr_pkg::stage_t d,
  output prr_pkg::stage_t q
);

  logic [2*prr_pkg::RANK_W-1:0] prod;
  prr_pkg::stage_t              q_next;

  always_comb begin
    prod = {{prr_pkg::RANK_W{1'b0}}, d.acc} * {{prr_pkg::RANK_W{1'b0}}, prr_pkg::RECIP[n]};
    q_next     = d;
    q_next.quo = prod[2*prr_pkg::RANK_W-1:prr_pkg::RANK_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q <= q_next;
    end
  end

endmodule

/* hdl/prr_level.sv */
module prr_level (
  input  logic            clk,
  input  logic            rst,
  input  prr_pkg::elem_t  n,
  input  prr_pkg::stage_t d,
  output prr_pkg::stage_t q
);

  prr_pkg::elem_t                            idx;
  prr_pkg::elem_t                            sv;
  prr_pkg::elem_t                            j;
  prr_pkg::elem_t                            k;
  prr_pkg::elem_t [prr_pkg::PERM_LENGTH-1:0] pr;
  prr_pkg::elem_t [prr_pkg::PERM_LENGTH-1:0] rr;
  prr_pkg::elem_t [prr_pkg::PERM_LENGTH-1:0] pu;
  prr_pkg::rank_t                            sw;
  prr_pkg::rank_t                            qn;
  prr_pkg::rank_t                            rem0;
  prr_pkg::rank_t                            rem;
  logic                                      corr;
  prr_pkg::stage_t                           q_next;

  always_comb begin
    idx = n - prr_pkg::elem_t'(1);

    sv = d.p[idx];
    j  = d.r[idx];
    pr = d.p;
    pr[idx] = d.p[j];
    pr[j]   = d.p[idx];
    rr = d.r;
    rr[sv]  = d.r[idx];
    rr[idx] = d.r[sv];
    sw = prr_pkg::rank_t'(sv) * prr_pkg::WEIGHT[n];

    // The estimated quotient is exact or one short; one correction step fixes it.
    qn   = d.quo * prr_pkg::rank_t'(n);
    rem0 = d.acc - qn;
    corr = (rem0 >= prr_pkg::rank_t'(n));
    rem  = corr ? (rem0 - prr_pkg::rank_t'(n)) : rem0;
    k    = rem[prr_pkg::ELEM_W-1:0];
    pu = d.p;
    pu[idx] = d.p[k];
    pu[k]   = d.p[idx];

    q_next = d;
    if (d.op == prr_pkg::OP_UNRANK) begin
      q_next.p   = pu;
      q_next.acc = corr ? (d.quo + prr_pkg::rank_t'(1)) : d.quo;
    end else begin
      q_next.p   = pr;
      q_next.r   = rr;
      q_next.acc = d.acc + sw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q <= q_next;
    end
  end

endmodule

/* hdl/permutation_rank_unrank.sv */
// Throughput: one transaction per cycle; busy is always low.
// The pipeline is a front stage, eight levels of reciprocal and swap stages, and an output register.
// Synchronous active-high reset clears all valid bits; no results appear until new starts.
// Results are strobed by done for one cycle and cannot be stalled.
module permutation_rank_unrank (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [3:0]  elem_in_0,
  input  logic [3:0]  elem_in_1,
  input  logic [3:0]  elem_in_2,
  input  logic [3:0]  elem_in_3,
  input  logic [3:0]  elem_in_4,
  input  logic [3:0]  elem_in_5,
  input  logic [3:0]  elem_in_6,
  input  logic [3:0]  elem_in_7,
  input  logic [3:0]  elem_in_8,
  input  logic [18:0] rank_in,
  output logic        done,
  output logic [3:0]  elem_out_0,
  output logic [3:0]  elem_out_1,
  output logic [3:0]  elem_out_2,
  output logic [3:0]  elem_out_3,
  output logic [3:0]  elem_out_4,
  output logic [3:0]  elem_out_5,
  output logic [3:0]  elem_out_6,
  output logic [3:0]  elem_out_7,
  output logic [3:0]  elem_out_8,
  output logic [18:0] rank_out
);

  prr_pkg::elem_t [prr_pkg::PERM_LENGTH-1:0] elem_in;
  prr_pkg::elem_t [prr_pkg::PERM_LENGTH-1:0] elem_res;
  prr_pkg::rank_t                            rank_res;
  prr_pkg::stage_t                           front_q;
  prr_pkg::stage_t                           a_q [prr_pkg::NUM_LEVELS];
  prr_pkg::stage_t                           b_q [prr_pkg::NUM_LEVELS];
  prr_pkg::stage_t                           last;

  assign busy = 1'b0;

  assign elem_in = {elem_in_8, elem_in_7, elem_in_6, elem_in_5, elem_in_4,
                    elem_in_3, elem_in_2, elem_in_1, elem_in_0};

  prr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (start & ~busy),
    .op      (prr_pkg::op_t'(op)),
    .elem_in (elem_in),
    .rank_in (rank_in),
    .q       (front_q)
  );

  for (genvar g = 0; g < prr_pkg::NUM_LEVELS; g++) begin : g_level
    prr_recip u_recip (
      .clk (clk),
      .rst (rst),
      .n   (prr_pkg::elem_t'(prr_pkg::PERM_LENGTH - g)),
      .d   ((g == 0) ? front_q : b_q[(g == 0) ? 0 : g - 1]),
      .q   (a_q[g])
    );

    prr_level u_level (
      .clk (clk),
      .rst (rst),
      .n   (prr_pkg::elem_t'(prr_pkg::PERM_LENGTH - g)),
      .d   (a_q[g]),
      .q   (b_q[g])
    );
  end

  assign last = b_q[prr_pkg::NUM_LEVELS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
    elem_res <= (last.op == prr_pkg::OP_UNRANK) ? last.p : '0;
    rank_res <= (last.op == prr_pkg::OP_RANK) ? last.acc : '0;
  end

  assign elem_out_0 = elem_res[0];
  assign elem_out_1 = elem_res[1];
  assign elem_out_2 = elem_res[2];
  assign elem_out_3 = elem_res[3];
  assign elem_out_4 = elem_res[4];
  assign elem_out_5 = elem_res[5];
  assign elem_out_6 = elem_res[6];
  assign elem_out_7 = elem_res[7];
  assign elem_out_8 = elem_res[8];
  assign rank_out   = rank_res;

  a_start_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(prr_pkg::LATENCY) done)
    else $error("accepted transaction produced no result");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##(prr_pkg::LATENCY) !done)
    else $error("result without an accepted transaction");

  a_one_field: assert property (@(posedge clk) disable iff (rst)
    done |-> (rank_out == '0) || (elem_res == '0))
    else $error("both rank and element fields are nonzero");

endmodule
